// ----- sv/rtc_three_wire_burst_master_unit_defines.svh -----
// ----------------------------------------------------------------------------
// RTC three-wire burst master assertion macros
// Shared concurrent assertion forms for the serial master.
// ----------------------------------------------------------------------------
`ifndef RTC_THREE_WIRE_BURST_MASTER_UNIT_DEFINES_SVH
`define RTC_THREE_WIRE_BURST_MASTER_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RTCB_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RTCB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/rtcb_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RTC three-wire burst master package
// Sequence codes, command bytes and the beat types shared by the design.
// ----------------------------------------------------------------------------
package rtcb_pkg;

    localparam logic [1:0] C_KIND_TICK  = 2'd0;
    localparam logic [1:0] C_KIND_INIT  = 2'd1;
    localparam logic [1:0] C_KIND_WRITE = 2'd2;
    localparam logic [1:0] C_KIND_READ  = 2'd3;

    localparam logic [2:0] C_MODE_IDLE   = 3'd0;
    localparam logic [2:0] C_MODE_INIT   = 3'd1;
    localparam logic [2:0] C_MODE_WRITE  = 3'd2;
    localparam logic [2:0] C_MODE_READ   = 3'd3;
    localparam logic [2:0] C_MODE_REPAIR = 3'd4;

    localparam logic [7:0] C_CMD_PROTECT = 8'h8E;
    localparam logic [7:0] C_CMD_BURST_W = 8'hBE;
    localparam logic [7:0] C_CMD_BURST_R = 8'hBF;
    localparam logic [7:0] C_SEC_LIMIT   = 8'h61;
    localparam logic [7:0] C_ZERO_BYTE   = 8'h00;

    typedef struct packed {
        logic [1:0]  kind;
        logic [55:0] time_in;
        logic        io_in;
    } t_item;

    typedef struct packed {
        logic        chip_enable;
        logic        serial_clock;
        logic        io_out;
        logic        io_drive;
        logic        busy_res;
        logic        done_res;
        logic [55:0] time_out;
        logic        seconds_repaired;
    } t_result;

endpackage

// ----- sv/rtcb_in_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RTC burst master input channel
// Valid/ready channel carrying one input beat.
// ----------------------------------------------------------------------------
interface rtcb_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [55:0] time_in;
    logic        io_in;

    modport source (output valid, output kind, output time_in, output io_in, input ready);
    modport sink (input valid, input kind, input time_in, input io_in, output ready);
endinterface

// ----- sv/rtcb_out_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RTC burst master result channel
// Valid/ready channel carrying one result beat with the pin levels.
// ----------------------------------------------------------------------------
interface rtcb_out_if;
    logic        valid;
    logic        ready;
    logic        chip_enable;
    logic        serial_clock;
    logic        io_out;
    logic        io_drive;
    logic        busy_res;
    logic        done_res;
    logic [55:0] time_out;
    logic        seconds_repaired;

    modport source (
        output valid, output chip_enable, output serial_clock, output io_out,
        output io_drive, output busy_res, output done_res, output time_out,
        output seconds_repaired, input ready
    );
    modport sink (
        input valid, input chip_enable, input serial_clock, input io_out,
        input io_drive, input busy_res, input done_res, input time_out,
        input seconds_repaired, output ready
    );
endinterface

// ----- sv/rtcb_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RTC burst master sequencer core
// Holds the transfer state and advances it by one beat when stepped.
// ----------------------------------------------------------------------------
module rtcb_core
    import rtcb_pkg::*;
#(
    parameter int BURST_BYTES = 7
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_step,
    input  t_item   i_item,
    output t_result o_result
);

    localparam logic [3:0] L_BB = 4'(BURST_BYTES);

    logic [2:0]  r_mode,  n_mode;
    logic [3:0]  r_byte,  n_byte;
    logic [2:0]  r_bit,   n_bit;
    logic        r_phase, n_phase;
    logic [7:0]  r_shift, n_shift;
    logic [55:0] r_tbuf,  n_tbuf;
    logic        r_ce,    n_ce;
    logic        r_rep,   n_rep;

    function automatic logic [3:0] f_seq_len(input logic [2:0] mode);
        logic [3:0] len;
        len = 4'd0;
        if (mode == C_MODE_INIT) len = 4'd2;
        else if (mode == C_MODE_READ) len = L_BB + 4'd1;
        else if (mode == C_MODE_WRITE || mode == C_MODE_REPAIR) len = L_BB + 4'd2;
        return len;
    endfunction

    function automatic logic [7:0] f_buf_byte(input logic [55:0] tb, input logic [2:0] k);
        logic [63:0] ext;
        ext = {8'h00, tb};
        return ext[{k, 3'b000} +: 8];
    endfunction

    function automatic logic f_is_read(input logic [2:0] mode, input logic [3:0] idx);
        return (mode == C_MODE_READ) && (idx >= 4'd1) && (idx <= L_BB);
    endfunction

    function automatic logic [7:0] f_to_send(input logic [2:0] mode, input logic [3:0] idx,
                                             input logic [55:0] tb);
        logic [7:0] val;
        logic [3:0] prev;
        prev = idx - 4'd1;
        val = C_ZERO_BYTE;
        if (idx == 4'd0) begin
            if (mode == C_MODE_INIT) val = C_CMD_PROTECT;
            else if (mode == C_MODE_READ) val = C_CMD_BURST_R;
            else val = C_CMD_BURST_W;
        end else if (mode == C_MODE_WRITE && idx <= L_BB) begin
            val = f_buf_byte(tb, prev[2:0]);
        end else if (mode == C_MODE_REPAIR && idx >= 4'd2 && idx <= L_BB) begin
            val = f_buf_byte(tb, prev[2:0]);
        end
        return val;
    endfunction

    logic       w_done;
    logic       w_active;
    logic       w_drive;
    logic [3:0] w_prev;

    always_comb begin
        n_mode  = r_mode;
        n_byte  = r_byte;
        n_bit   = r_bit;
        n_phase = r_phase;
        n_shift = r_shift;
        n_tbuf  = r_tbuf;
        n_ce    = r_ce;
        n_rep   = r_rep;
        w_done  = 1'b0;
        w_prev  = r_byte - 4'd1;
        if (i_step) begin
            if (r_mode == C_MODE_IDLE) begin
                unique case (i_item.kind)
                    C_KIND_INIT: begin
                        n_mode  = C_MODE_INIT;
                        n_shift = C_CMD_PROTECT;
                        n_ce    = 1'b1;
                    end
                    C_KIND_WRITE: begin
                        n_tbuf  = i_item.time_in;
                        n_mode  = C_MODE_WRITE;
                        n_shift = C_CMD_BURST_W;
                        n_ce    = 1'b1;
                    end
                    C_KIND_READ: begin
                        n_mode  = C_MODE_READ;
                        n_shift = C_CMD_BURST_R;
                        n_ce    = 1'b1;
                    end
                    default: begin
                    end
                endcase
                if (i_item.kind != C_KIND_TICK) begin
                    n_byte  = 4'd0;
                    n_bit   = 3'd0;
                    n_phase = 1'b0;
                end
            end else if (i_item.kind == C_KIND_TICK) begin
                if (!r_phase && r_ce && f_is_read(r_mode, r_byte)) begin
                    n_shift = {i_item.io_in, r_shift[7:1]};
                end
                if (!r_ce) begin
                    n_ce = 1'b1;
                end else if (r_byte >= f_seq_len(r_mode)) begin
                    n_ce    = 1'b0;
                    n_byte  = 4'd0;
                    n_bit   = 3'd0;
                    n_phase = 1'b0;
                    if (r_mode == C_MODE_READ) begin
                        n_rep = (f_buf_byte(r_tbuf, 3'd0) >= C_SEC_LIMIT);
                    end
                    if (r_mode == C_MODE_READ && n_rep) begin
                        n_mode  = C_MODE_REPAIR;
                        n_shift = C_CMD_BURST_W;
                    end else begin
                        n_mode = C_MODE_IDLE;
                        w_done = 1'b1;
                    end
                end else if (!r_phase) begin
                    n_phase = 1'b1;
                end else begin
                    n_phase = 1'b0;
                    if (!f_is_read(r_mode, r_byte)) begin
                        n_shift = {1'b0, n_shift[7:1]};
                    end
                    if (r_bit != 3'd7) begin
                        n_bit = r_bit + 3'd1;
                    end else begin
                        n_bit = 3'd0;
                        if (f_is_read(r_mode, r_byte) && r_byte <= 4'd7) begin
                            n_tbuf[{w_prev[2:0], 3'b000} +: 8] = n_shift;
                        end
                        n_byte  = r_byte + 4'd1;
                        n_shift = f_to_send(r_mode, n_byte, n_tbuf);
                    end
                end
            end
        end
        w_active = (n_mode != C_MODE_IDLE);
        w_drive  = w_active && (n_byte < f_seq_len(n_mode)) && !f_is_read(n_mode, n_byte);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= C_MODE_IDLE;
            r_byte  <= 4'd0;
            r_bit   <= 3'd0;
            r_phase <= 1'b0;
            r_shift <= 8'h00;
            r_tbuf  <= 56'h0;
            r_ce    <= 1'b0;
            r_rep   <= 1'b0;
        end else begin
            r_mode  <= n_mode;
            r_byte  <= n_byte;
            r_bit   <= n_bit;
            r_phase <= n_phase;
            r_shift <= n_shift;
            r_tbuf  <= n_tbuf;
            r_ce    <= n_ce;
            r_rep   <= n_rep;
        end
    end

    always_comb begin
        o_result.chip_enable      = n_ce;
        o_result.serial_clock     = w_active && n_phase;
        o_result.io_out           = w_drive && n_shift[0];
        o_result.io_drive         = w_drive;
        o_result.busy_res         = w_active;
        o_result.done_res         = w_done;
        o_result.time_out         = n_tbuf;
        o_result.seconds_repaired = n_rep;
    end

endmodule

// ----- sv/rtc_three_wire_burst_master_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RTC three-wire burst master
// Drives a three-wire clock chip one pin phase per tick beat.
// ----------------------------------------------------------------------------
//  Channel    Dir   Beat contents
//  i_item     in    kind, time_in, io_in
//  o_result   out   pin levels, busy, done, time_out, seconds_repaired
//
// Every input beat produces exactly one result beat, one beat per cycle
// while the result channel is ready. A beat passes an input register,
// then the sequencer step and the result register.
// Reset is synchronous and active low; it clears all sequencer state.
// A stalled result register holds, and the input register keeps taking
// beats until it is full as well.
// ----------------------------------------------------------------------------
`include "rtc_three_wire_burst_master_unit_defines.svh"

module rtc_three_wire_burst_master_unit
    import rtcb_pkg::*;
#(
    parameter int BURST_BYTES = 7
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    rtcb_in_if.sink     i_item,
    rtcb_out_if.source  o_result
);

    logic    r_in_valid;
    t_item   r_in;
    logic    r_out_valid;
    t_result r_out;
    logic    w_move;
    t_result w_res;

    assign w_move       = r_in_valid && (!r_out_valid || o_result.ready);
    assign i_item.ready = !r_in_valid || w_move;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_item.ready) begin
            r_in_valid <= i_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.ready && i_item.valid) begin
            r_in.kind    <= i_item.kind;
            r_in.time_in <= i_item.time_in;
            r_in.io_in   <= i_item.io_in;
        end
    end

    rtcb_core #(
        .BURST_BYTES(BURST_BYTES)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_move),
        .i_item  (r_in),
        .o_result(w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_move) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_move) begin
            r_out <= w_res;
        end
    end

    assign o_result.valid            = r_out_valid;
    assign o_result.chip_enable      = r_out.chip_enable;
    assign o_result.serial_clock     = r_out.serial_clock;
    assign o_result.io_out           = r_out.io_out;
    assign o_result.io_drive         = r_out.io_drive;
    assign o_result.busy_res         = r_out.busy_res;
    assign o_result.done_res         = r_out.done_res;
    assign o_result.time_out         = r_out.time_out;
    assign o_result.seconds_repaired = r_out.seconds_repaired;

    `RTCB_ASSERT_IMP(a_done_idle, i_clk, i_rst_n, r_out_valid && r_out.done_res,
        !r_out.busy_res && !r_out.chip_enable, "done beat while still busy")
    `RTCB_ASSERT_IMP(a_io_quiet, i_clk, i_rst_n, r_out_valid && !r_out.io_drive,
        !r_out.io_out, "data driven while line released")
    `RTCB_ASSERT_IMP(a_idle_clock, i_clk, i_rst_n, r_out_valid && !r_out.busy_res,
        !r_out.serial_clock && !r_out.chip_enable, "pins active while idle")
    `RTCB_ASSERT_NEXT(a_in_hold, i_clk, i_rst_n, r_in_valid && !w_move,
        r_in_valid, "held input beat lost")
    `RTCB_ASSERT_NEXT(a_out_fill, i_clk, i_rst_n, w_move,
        r_out_valid, "stepped beat missing from result register")

endmodule
